// ===== sv/fcdma_pkg.sv =====
// Shared types, constants and helpers for the four-channel dma address engine.
// No dependencies; every other file refers to it by scoped names.
package fcdma_pkg;

  // number of implemented channels (channel field stays two bits wide)
  localparam int CHANNELS = 4;

  localparam int CH_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 16;
  localparam int CTL_W    = 16;

  // control register fields
  localparam int DMODE_LO = 5;
  localparam int SMODE_LO = 7;
  localparam int WSZ_BIT  = 10;
  localparam int IRQ_BIT  = 14;

  // unit sizes in bytes
  localparam logic [ADDR_W-1:0] SIZE_WORD = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] SIZE_HALF = ADDR_W'(2);

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_SRC  = 2'd0,
    REG_DST  = 2'd1,
    REG_CNT  = 2'd2,
    REG_CTL  = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    AM_INC    = 2'd0,
    AM_DEC    = 2'd1,
    AM_FIXED  = 2'd2,
    AM_RELOAD = 2'd3
  } addr_mode_e;

  // one input item
  typedef struct packed {
    opcode_e             opcode;
    logic [CH_W-1:0]     channel;
    reg_sel_e            register_select;
    logic [ADDR_W-1:0]   register_value;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic                access_valid;
    logic [CH_W-1:0]     served_channel;
    logic [ADDR_W-1:0]   read_address;
    logic [ADDR_W-1:0]   write_address;
    logic                word_size;
    logic                last_unit;
    logic                irq_request;
  } out_item_t;

  // channel choice for a step
  typedef struct packed {
    logic                found;
    logic                from_pending;
    logic [CH_W-1:0]     ch;
  } chan_sel_t;

  // address after one unit
  function automatic logic [ADDR_W-1:0] step_address(
    input logic [ADDR_W-1:0] addr,
    input addr_mode_e        mode,
    input logic [ADDR_W-1:0] size
  );
    logic [ADDR_W-1:0] res;
    case (mode)
      AM_INC, AM_RELOAD: res = addr + size;
      AM_DEC:            res = addr - size;
      default:           res = addr;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/fcdma_arb.sv =====
// Channel choice for a step: the active channel, else the lowest pending one.
// Depends on fcdma_pkg.
module fcdma_arb (
  input  logic [fcdma_pkg::CHANNELS-1:0] pending_i,
  input  logic                           active_i,
  input  logic [fcdma_pkg::CH_W-1:0]     active_ch_i,
  output fcdma_pkg::chan_sel_t           sel_o
);

  // lowest set pending bit, scanned from the top so the lowest wins
  always_comb begin
    sel_o = '0;
    if (active_i) begin
      sel_o.found = 1'b1;
      sel_o.ch    = active_ch_i;
    end else begin
      for (int i = fcdma_pkg::CHANNELS - 1; i >= 0; i--) begin
        if (pending_i[i]) begin
          sel_o.found        = 1'b1;
          sel_o.from_pending = 1'b1;
          sel_o.ch           = fcdma_pkg::CH_W'(i);
        end
      end
    end
  end

endmodule

// ===== sv/fcdma_core.sv =====
// Channel register file and single-pass item execution for the dma engine.
// Depends on fcdma_pkg and fcdma_arb.
module fcdma_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 proc_i,
  input  fcdma_pkg::in_item_t  item_i,
  output logic                 res_valid_o,
  output fcdma_pkg::out_item_t res_o
);

  localparam int N = fcdma_pkg::CHANNELS;
  localparam int AW = fcdma_pkg::ADDR_W;

  logic [AW-1:0]                src_q  [N];
  logic [AW-1:0]                src_d  [N];
  logic [AW-1:0]                dst_q  [N];
  logic [AW-1:0]                dst_d  [N];
  logic [AW-1:0]                sdst_q [N];
  logic [AW-1:0]                sdst_d [N];
  logic [fcdma_pkg::CNT_W-1:0]  wcnt_q [N];
  logic [fcdma_pkg::CNT_W-1:0]  wcnt_d [N];
  logic [fcdma_pkg::CTL_W-1:0]  ctl_q  [N];
  logic [fcdma_pkg::CTL_W-1:0]  ctl_d  [N];
  logic [fcdma_pkg::CNT_W-1:0]  rem_q  [N];
  logic [fcdma_pkg::CNT_W-1:0]  rem_d  [N];
  logic [N-1:0]                 pend_q, pend_d;
  logic                         active_q, active_d;
  logic [fcdma_pkg::CH_W-1:0]   act_ch_q, act_ch_d;

  fcdma_pkg::chan_sel_t         sel;

  fcdma_arb u_arb (
    .pending_i   (pend_q),
    .active_i    (active_q),
    .active_ch_i (act_ch_q),
    .sel_o       (sel)
  );

  // one item against the channel state
  always_comb begin
    logic [fcdma_pkg::CH_W-1:0]  ch;
    logic [fcdma_pkg::CH_W-1:0]  c;
    logic                        ch_ok;
    logic [fcdma_pkg::CTL_W-1:0] ctl;
    fcdma_pkg::addr_mode_e       dmode;
    fcdma_pkg::addr_mode_e       smode;
    logic                        wsz;
    logic [AW-1:0]               size;
    logic                        last;

    src_d    = src_q;
    dst_d    = dst_q;
    sdst_d   = sdst_q;
    wcnt_d   = wcnt_q;
    ctl_d    = ctl_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    active_d = active_q;
    act_ch_d = act_ch_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    ch    = item_i.channel;
    ch_ok = (int'(ch) < N);
    c     = sel.ch;
    ctl   = ctl_q[c];
    dmode = fcdma_pkg::addr_mode_e'(ctl[fcdma_pkg::DMODE_LO +: 2]);
    smode = fcdma_pkg::addr_mode_e'(ctl[fcdma_pkg::SMODE_LO +: 2]);
    wsz   = ctl[fcdma_pkg::WSZ_BIT];
    size  = wsz ? fcdma_pkg::SIZE_WORD : fcdma_pkg::SIZE_HALF;
    last  = (rem_q[c] <= fcdma_pkg::CNT_W'(1));

    if (proc_i) begin
      case (item_i.opcode)
        fcdma_pkg::OP_WRITE: begin
          if (ch_ok) begin
            case (item_i.register_select)
              fcdma_pkg::REG_SRC: src_d[ch] = item_i.register_value;
              fcdma_pkg::REG_DST: dst_d[ch] = item_i.register_value;
              fcdma_pkg::REG_CNT:
                wcnt_d[ch] = item_i.register_value[fcdma_pkg::CNT_W-1:0];
              default:
                ctl_d[ch] = item_i.register_value[fcdma_pkg::CTL_W-1:0];
            endcase
          end
        end
        fcdma_pkg::OP_START: begin
          // a start of the running channel or with zero count is dropped
          if (ch_ok && !(active_q && act_ch_q == ch) &&
              wcnt_q[ch] != '0) begin
            rem_d[ch]  = wcnt_q[ch];
            sdst_d[ch] = dst_q[ch];
            pend_d[ch] = 1'b1;
          end
        end
        fcdma_pkg::OP_STEP: begin
          if (sel.found) begin
            if (sel.from_pending) begin
              pend_d[c] = 1'b0;
            end
            res_valid_o          = 1'b1;
            res_o.access_valid   = 1'b1;
            res_o.served_channel = c;
            res_o.read_address   = src_q[c];
            res_o.write_address  = dst_q[c];
            res_o.word_size      = wsz;
            res_o.last_unit      = last;
            res_o.irq_request    = last & ctl[fcdma_pkg::IRQ_BIT];
            // the forbidden source mode keeps the source fixed
            src_d[c] = fcdma_pkg::step_address(src_q[c],
                         (smode == fcdma_pkg::AM_RELOAD) ? fcdma_pkg::AM_FIXED : smode,
                         size);
            dst_d[c] = fcdma_pkg::step_address(dst_q[c], dmode, size);
            if (last) begin
              rem_d[c] = '0;
              active_d = 1'b0;
              act_ch_d = c;
              if (dmode == fcdma_pkg::AM_RELOAD) begin
                dst_d[c] = sdst_q[c];
              end
            end else begin
              rem_d[c] = rem_q[c] - fcdma_pkg::CNT_W'(1);
              active_d = 1'b1;
              act_ch_d = c;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // channel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        src_q[i]  <= '0;
        dst_q[i]  <= '0;
        sdst_q[i] <= '0;
        wcnt_q[i] <= '0;
        ctl_q[i]  <= '0;
        rem_q[i]  <= '0;
      end
      pend_q   <= '0;
      active_q <= 1'b0;
      act_ch_q <= '0;
    end else begin
      src_q    <= src_d;
      dst_q    <= dst_d;
      sdst_q   <= sdst_d;
      wcnt_q   <= wcnt_d;
      ctl_q    <= ctl_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
      active_q <= active_d;
      act_ch_q <= act_ch_d;
    end
  end

  // running channel is never also pending
  a_active_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !pend_q[act_ch_q])
    else $error("active channel still marked pending");

  // running channel always has units left
  a_active_has_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> rem_q[act_ch_q] != '0)
    else $error("active channel with no remaining units");

  // the final unit ends the transfer
  a_last_clears_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_unit) |=> !active_q)
    else $error("channel still active after its last unit");

endmodule

// ===== sv/fcdma_outreg.sv =====
// Result register of the dma engine with its stream-side handshake.
// Depends on fcdma_pkg.
module fcdma_outreg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 proc_i,
  input  logic                 res_valid_i,
  input  fcdma_pkg::out_item_t res_i,
  input  logic                 ready_i,
  output logic                 free_o,
  output logic                 valid_o,
  output fcdma_pkg::out_item_t res_o
);

  logic                 vld_q, vld_d;
  fcdma_pkg::out_item_t res_q;

  // empty, or emptied by the receiver in this cycle
  assign free_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

  // valid follows the executed item, else drops when taken
  always_comb begin
    if (proc_i) begin
      vld_d = res_valid_i;
    end else begin
      vld_d = vld_q && !ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (proc_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== sv/four_channel_dma_address_engine.sv =====
// Top level of the four-channel dma address engine: input register, core, result register.
// Depends on fcdma_pkg, fcdma_core and fcdma_arb, fcdma_outreg.
//
// Usage:
//   The slave stream carries commands: tuser holds the opcode (register write,
//   channel start, step). tdata holds channel, register select and value.
//   A register write sets a channel's source, destination, word count or
//   control; a start arms the channel; each step issues one transfer unit of
//   the active or lowest pending channel and yields one item on the master
//   stream. Writes, starts and idle steps yield no item.
//   The master stream carries the unit: tdata holds access flag, channel, read
//   and write address and interrupt flag, tuser the word size, tlast the
//   final unit of the channel's transfer.
//   An accepted item waits in the input register until the result register is
//   free, then is executed and its result offered. Throughput is one item per
//   cycle unless the receiver stalls, set by the channel register read-modify-write.
//   Reset clears all channel registers, pending marks and the active channel.
//   When the receiver stalls, the result register holds its item, the input
//   register holds the next one and tready drops until the result is taken.
module four_channel_dma_address_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel [1:0], register_select [3:2], register_value [35:4], zero pad
  input  logic [fcdma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode [1:0]
  input  logic [fcdma_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // access_valid [0], served_channel [2:1], read_address [34:3],
  // write_address [66:35], irq_request [67], zero pad
  output logic [fcdma_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // word_size [0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  logic                 in_vld_q, in_vld_d;
  fcdma_pkg::in_item_t  in_q;
  fcdma_pkg::in_item_t  in_item;
  logic                 proc;
  logic                 out_free;
  logic                 res_valid;
  fcdma_pkg::out_item_t res;
  fcdma_pkg::out_item_t out_res;

  // unpack the slave item
  always_comb begin
    in_item.opcode          = fcdma_pkg::opcode_e'(s_axis_tuser);
    in_item.channel         = s_axis_tdata[1:0];
    in_item.register_select = fcdma_pkg::reg_sel_e'(s_axis_tdata[3:2]);
    in_item.register_value  = s_axis_tdata[35:4];
  end

  // execute when an item waits and the result register can take it
  assign proc          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || proc;

  always_comb begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else begin
      in_vld_d = in_vld_q && !proc;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_item;
    end
  end

  fcdma_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fcdma_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_i     (m_axis_tready),
    .free_o      (out_free),
    .valid_o     (m_axis_tvalid),
    .res_o       (out_res)
  );

  // pack the master item
  assign m_axis_tdata = {4'b0000, out_res.irq_request, out_res.write_address,
                         out_res.read_address, out_res.served_channel,
                         out_res.access_valid};
  assign m_axis_tuser = out_res.word_size;
  assign m_axis_tlast = out_res.last_unit;

endmodule
